// ===== design/kde_pkg.sv =====
package kde_pkg;

   // register file
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEBOUNCE_TIME   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LONG_PRESS_TIME = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REPEAT_PERIOD   = 2'd2;

   localparam logic [CSR_DATA_WIDTH-1:0] DEBOUNCE_RESET   = 16'd20;
   localparam logic [CSR_DATA_WIDTH-1:0] LONG_PRESS_RESET = 16'd600;
   localparam logic [CSR_DATA_WIDTH-1:0] REPEAT_RESET     = 16'd0;

   localparam int TIME_WIDTH = 32;

   // event codes
   localparam logic [2:0] EV_PRESS   = 3'd0;
   localparam logic [2:0] EV_LONG    = 3'd1;
   localparam logic [2:0] EV_REPEAT  = 3'd2;
   localparam logic [2:0] EV_RELEASE = 3'd3;
   localparam logic [2:0] EV_CLICK   = 3'd4;

   // result queue default depth, at least two
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   typedef enum logic [3:0] {
      PH_IDLE       = 4'b0001,
      PH_GOING_DOWN = 4'b0010,
      PH_DOWN       = 4'b0100,
      PH_GOING_UP   = 4'b1000
   } phase_type;

   typedef struct packed {
      logic                  key_level;
      logic [TIME_WIDTH-1:0] time_now;
   } req_payload_type;

   typedef struct packed {
      logic [2:0] event_code;
      logic       last_event;
   } rsp_payload_type;

   // results of one scan, handed from the state machine to the queue
   typedef struct packed {
      logic [1:0]      count;
      rsp_payload_type first;
      rsp_payload_type second;
   } scan_events_type;

endpackage

// ===== design/key_debounce_event_fsm_unit.sv =====
// channel   direction  handshake           payload
// req       in         req_valid/req_stall  key_level, time_now
// rsp       out        rsp_valid/rsp_stall  event_code, last_event
// csr       in         csr_write_enable     csr_index, csr_write_data
//
// one scan is taken per cycle while req_stall is low; its results enter
// the result queue on the same edge and leave on rsp in order, one per
// cycle while rsp_stall is low; a scan yields zero, one or two results
// (release then click); req_stall rises while the result queue has fewer
// than two free slots; reset is synchronous and returns the state machine
// to idle and the registers to 20 ms debounce, 600 ms long press, repeat off
module key_debounce_event_fsm_unit #(
   parameter int QUEUE_DEPTH = kde_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // scan input
   input  logic                                req_valid,
   output logic                                req_stall,
   input  kde_pkg::req_payload_type            req_data,
   // event output
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output kde_pkg::rsp_payload_type            rsp_data,
   // register writes
   input  logic                                csr_write_enable,
   input  logic [kde_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [kde_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);

   kde_pkg::scan_events_type events;
   logic                     queue_full;
   logic                     req_accept;

   // stall only depends on queue occupancy, never on req_valid
   assign req_stall  = queue_full;
   assign req_accept = req_valid && !req_stall;

   // debounce state machine, compares and config registers
   kde_core u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .item_accept      (req_accept),
      .item             (req_data),
      .events           (events)
   );

   // result queue, parts the scan side from the event consumer
   kde_outq #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .events    (events),
      .full      (queue_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== design/kde_core.sv =====
module kde_core (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_write_enable,
   input  logic [kde_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [kde_pkg::CSR_DATA_WIDTH-1:0]      csr_write_data,
   input  logic                                    item_accept,
   input  kde_pkg::req_payload_type                item,
   output kde_pkg::scan_events_type                events
);

   logic [kde_pkg::CSR_DATA_WIDTH-1:0] debounce_ff, debounce_in;
   logic [kde_pkg::CSR_DATA_WIDTH-1:0] long_time_ff, long_time_in;
   logic [kde_pkg::CSR_DATA_WIDTH-1:0] repeat_ff, repeat_in;

   kde_pkg::phase_type                 phase_ff, phase_in;
   logic                               long_fired_ff, long_fired_in;
   logic [kde_pkg::TIME_WIDTH-1:0]     edge_time_ff, edge_time_in;
   logic [kde_pkg::TIME_WIDTH-1:0]     hold_start_ff, hold_start_in;
   logic [kde_pkg::TIME_WIDTH-1:0]     anchor_ff, anchor_in;

   logic [kde_pkg::TIME_WIDTH-1:0]     db_eff;
   logic [kde_pkg::TIME_WIDTH-1:0]     edge_elapsed;
   logic [kde_pkg::TIME_WIDTH-1:0]     hold_elapsed;
   logic [kde_pkg::TIME_WIDTH-1:0]     anchor_elapsed;
   logic                               db_done, long_due, repeat_due;

   // register writes
   always_comb begin
      debounce_in  = debounce_ff;
      long_time_in = long_time_ff;
      repeat_in    = repeat_ff;
      if (csr_write_enable) begin
         case (csr_index)
            kde_pkg::CSR_DEBOUNCE_TIME:   debounce_in  = csr_write_data;
            kde_pkg::CSR_LONG_PRESS_TIME: long_time_in = csr_write_data;
            kde_pkg::CSR_REPEAT_PERIOD:   repeat_in    = csr_write_data;
            default: ;
         endcase
      end
   end

   // zero debounce acts as one
   assign db_eff = (debounce_ff == '0) ? kde_pkg::TIME_WIDTH'(1)
                                       : kde_pkg::TIME_WIDTH'(debounce_ff);

   // wrapping differences
   assign edge_elapsed   = item.time_now - edge_time_ff;
   assign hold_elapsed   = item.time_now - hold_start_ff;
   assign anchor_elapsed = item.time_now - anchor_ff;

   assign db_done    = edge_elapsed >= db_eff;
   assign long_due   = hold_elapsed >= kde_pkg::TIME_WIDTH'(long_time_ff);
   assign repeat_due = (repeat_ff != '0)
                       && (anchor_elapsed >= kde_pkg::TIME_WIDTH'(repeat_ff));

   always_comb begin
      phase_in      = phase_ff;
      long_fired_in = long_fired_ff;
      edge_time_in  = edge_time_ff;
      hold_start_in = hold_start_ff;
      anchor_in     = anchor_ff;
      events        = '0;
      case (phase_ff)
         kde_pkg::PH_IDLE: begin
            if (item.key_level) begin
               edge_time_in = item.time_now;
               phase_in     = kde_pkg::PH_GOING_DOWN;
            end
         end
         kde_pkg::PH_GOING_DOWN: begin
            if (!item.key_level) begin
               phase_in = kde_pkg::PH_IDLE;
            end else if (db_done) begin
               long_fired_in           = 1'b0;
               hold_start_in           = edge_time_ff + db_eff;
               events.count            = 2'd1;
               events.first.event_code = kde_pkg::EV_PRESS;
               events.first.last_event = 1'b1;
               phase_in                = kde_pkg::PH_DOWN;
            end
         end
         kde_pkg::PH_DOWN: begin
            if (!item.key_level) begin
               edge_time_in = item.time_now;
               phase_in     = kde_pkg::PH_GOING_UP;
            end else if (!long_fired_ff && long_due) begin
               long_fired_in           = 1'b1;
               anchor_in               = item.time_now;
               events.count            = 2'd1;
               events.first.event_code = kde_pkg::EV_LONG;
               events.first.last_event = 1'b1;
            end else if (long_fired_ff && repeat_due) begin
               // re-anchor on this scan, missed periods are dropped
               anchor_in               = item.time_now;
               events.count            = 2'd1;
               events.first.event_code = kde_pkg::EV_REPEAT;
               events.first.last_event = 1'b1;
            end
         end
         kde_pkg::PH_GOING_UP: begin
            if (item.key_level) begin
               phase_in = kde_pkg::PH_DOWN;
            end else if (db_done) begin
               events.first.event_code = kde_pkg::EV_RELEASE;
               if (long_fired_ff) begin
                  events.count            = 2'd1;
                  events.first.last_event = 1'b1;
               end else begin
                  events.count             = 2'd2;
                  events.first.last_event  = 1'b0;
                  events.second.event_code = kde_pkg::EV_CLICK;
                  events.second.last_event = 1'b1;
               end
               phase_in = kde_pkg::PH_IDLE;
            end
         end
         default: begin
            phase_in = kde_pkg::PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= kde_pkg::DEBOUNCE_RESET;
         long_time_ff  <= kde_pkg::LONG_PRESS_RESET;
         repeat_ff     <= kde_pkg::REPEAT_RESET;
         phase_ff      <= kde_pkg::PH_IDLE;
         long_fired_ff <= 1'b0;
         edge_time_ff  <= '0;
         hold_start_ff <= '0;
         anchor_ff     <= '0;
      end else begin
         debounce_ff  <= debounce_in;
         long_time_ff <= long_time_in;
         repeat_ff    <= repeat_in;
         if (item_accept) begin
            phase_ff      <= phase_in;
            long_fired_ff <= long_fired_in;
            edge_time_ff  <= edge_time_in;
            hold_start_ff <= hold_start_in;
            anchor_ff     <= anchor_in;
         end
      end
   end

endmodule

// ===== design/kde_outq.sv =====
module kde_outq #(
   parameter int QUEUE_DEPTH = kde_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  kde_pkg::scan_events_type  events,
   output logic                      full,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output kde_pkg::rsp_payload_type  rsp_data
);

   localparam int PTR_WIDTH   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0]   LAST_SLOT  = PTR_WIDTH'(QUEUE_DEPTH - 1);
   localparam logic [COUNT_WIDTH-1:0] FULL_LEVEL = COUNT_WIDTH'(QUEUE_DEPTH - 2);

   kde_pkg::rsp_payload_type   entry_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [COUNT_WIDTH-1:0]     count_ff, count_in;
   logic [PTR_WIDTH-1:0]       wr_ptr_next;
   logic [1:0]                 push_count;
   logic                       pop;

   function automatic logic [PTR_WIDTH-1:0] ptr_step(input logic [PTR_WIDTH-1:0] ptr);
      ptr_step = (ptr == LAST_SLOT) ? '0 : ptr + PTR_WIDTH'(1);
   endfunction

   assign push_count  = push ? events.count : 2'd0;
   assign pop         = rsp_valid && !rsp_stall;
   assign wr_ptr_next = ptr_step(wr_ptr_ff);

   // room for two results is kept free for the next scan
   assign full      = count_ff > FULL_LEVEL;
   assign rsp_valid = count_ff != '0;
   assign rsp_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      case (push_count)
         2'd1:    wr_ptr_in = wr_ptr_next;
         2'd2:    wr_ptr_in = ptr_step(wr_ptr_next);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = pop ? ptr_step(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + COUNT_WIDTH'(push_count) - COUNT_WIDTH'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= events.first;
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_ptr_next] <= events.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== design/kde_checker.sv =====
module kde_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input kde_pkg::rsp_payload_type rsp_data
);

   // held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // queue is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   // click always closes its scan
   a_click_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.event_code == kde_pkg::EV_CLICK |-> rsp_data.last_event)
      else $error("click not marked last");

   // second result of a scan is already queued
   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last_event |=>
         rsp_valid && rsp_data.event_code == kde_pkg::EV_CLICK)
      else $error("release not followed by click");

   // codes stay in range
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.event_code == kde_pkg::EV_PRESS
                 || rsp_data.event_code == kde_pkg::EV_LONG
                 || rsp_data.event_code == kde_pkg::EV_REPEAT
                 || rsp_data.event_code == kde_pkg::EV_RELEASE
                 || rsp_data.event_code == kde_pkg::EV_CLICK)
      else $error("unknown event code");

endmodule

bind key_debounce_event_fsm_unit kde_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== test/kde_event_checker.sv =====
module kde_event_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  kde_pkg::req_payload_type            req_data,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  kde_pkg::rsp_payload_type            rsp_data,
   input  logic                                csr_write_enable,
   input  logic [kde_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [kde_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data,
   output int                                  pending_count,
   output int                                  mismatch_count
);

   // timing registers as the block should hold them
   logic [kde_pkg::CSR_DATA_WIDTH-1:0] debounce_cfg;
   logic [kde_pkg::CSR_DATA_WIDTH-1:0] long_cfg;
   logic [kde_pkg::CSR_DATA_WIDTH-1:0] repeat_cfg;

   // key machine state
   kde_pkg::phase_type             key_phase;
   logic                           long_seen;
   logic [kde_pkg::TIME_WIDTH-1:0] bounce_start;
   logic [kde_pkg::TIME_WIDTH-1:0] hold_origin;
   logic [kde_pkg::TIME_WIDTH-1:0] repeat_mark;

   kde_pkg::rsp_payload_type due_events [$];

   function automatic void report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("mismatch: %s", msg);
   endfunction

   function automatic void track_key_scan(input logic pressed,
                                          input logic [kde_pkg::TIME_WIDTH-1:0] now);
      logic [2:0]                     fired [$];
      logic [kde_pkg::TIME_WIDTH-1:0] settle;
      kde_pkg::rsp_payload_type       ev;
      settle = (debounce_cfg == '0) ? 32'd1 : 32'(debounce_cfg);
      case (key_phase)
         kde_pkg::PH_IDLE: begin
            if (pressed) begin
               bounce_start = now;
               key_phase    = kde_pkg::PH_GOING_DOWN;
            end
         end
         kde_pkg::PH_GOING_DOWN: begin
            if (!pressed) begin
               key_phase = kde_pkg::PH_IDLE;
            end else if (now - bounce_start >= settle) begin
               long_seen   = 1'b0;
               hold_origin = bounce_start + settle;
               fired.push_back(kde_pkg::EV_PRESS);
               key_phase   = kde_pkg::PH_DOWN;
            end
         end
         kde_pkg::PH_DOWN: begin
            if (!pressed) begin
               bounce_start = now;
               key_phase    = kde_pkg::PH_GOING_UP;
            end else if (!long_seen && now - hold_origin >= 32'(long_cfg)) begin
               long_seen   = 1'b1;
               repeat_mark = now;
               fired.push_back(kde_pkg::EV_LONG);
            end else if (long_seen && repeat_cfg != '0 &&
                         now - repeat_mark >= 32'(repeat_cfg)) begin
               repeat_mark = now;
               fired.push_back(kde_pkg::EV_REPEAT);
            end
         end
         default: begin
            if (pressed) begin
               key_phase = kde_pkg::PH_DOWN;
            end else if (now - bounce_start >= settle) begin
               fired.push_back(kde_pkg::EV_RELEASE);
               if (!long_seen) fired.push_back(kde_pkg::EV_CLICK);
               key_phase = kde_pkg::PH_IDLE;
            end
         end
      endcase
      foreach (fired[k]) begin
         ev.event_code = fired[k];
         ev.last_event = (k == fired.size() - 1);
         due_events.push_back(ev);
      end
   endfunction

   always @(posedge clock) begin : watch
      kde_pkg::rsp_payload_type want;
      if (reset) begin
         debounce_cfg = kde_pkg::DEBOUNCE_RESET;
         long_cfg     = kde_pkg::LONG_PRESS_RESET;
         repeat_cfg   = kde_pkg::REPEAT_RESET;
         key_phase    = kde_pkg::PH_IDLE;
         long_seen    = 1'b0;
         bounce_start = '0;
         hold_origin  = '0;
         repeat_mark  = '0;
         due_events.delete();
      end else begin
         // scan first, so a write on the same edge counts from the next scan
         if (req_valid && !req_stall) track_key_scan(req_data.key_level, req_data.time_now);
         if (csr_write_enable) begin
            case (csr_index)
               kde_pkg::CSR_DEBOUNCE_TIME:   debounce_cfg = csr_write_data;
               kde_pkg::CSR_LONG_PRESS_TIME: long_cfg     = csr_write_data;
               kde_pkg::CSR_REPEAT_PERIOD:   repeat_cfg   = csr_write_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (due_events.size() == 0) begin
               report_mismatch($sformatf("unexpected event %0d last %0d",
                                         rsp_data.event_code, rsp_data.last_event));
            end else begin
               want = due_events.pop_front();
               if (rsp_data.event_code !== want.event_code ||
                   rsp_data.last_event !== want.last_event)
                  report_mismatch($sformatf("event %0d last %0d, expected event %0d last %0d",
                                            rsp_data.event_code, rsp_data.last_event,
                                            want.event_code, want.last_event));
            end
         end
      end
      pending_count = due_events.size();
   end

endmodule

// ===== test/tb_key_debounce_event_fsm_unit.sv =====
module tb_key_debounce_event_fsm_unit;

   // index with no register behind it, writes there must be dropped
   localparam logic [kde_pkg::CSR_INDEX_WIDTH-1:0] CSR_UNUSED = 2'd3;

   localparam int PLAN_PHASES = 8;
   localparam int PHASE_SCANS = 200;

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_stall;
   kde_pkg::req_payload_type            req_data;
   logic                                rsp_valid;
   logic                                rsp_stall;
   kde_pkg::rsp_payload_type            rsp_data;
   logic                                csr_write_enable;
   logic [kde_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [kde_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data;

   int pending_count;
   int mismatch_count;

   // stimulus bookkeeping
   logic [kde_pkg::TIME_WIDTH-1:0] now_ms;
   int unsigned                    settle_ms = 20;
   int unsigned                    span_ms   = 125;
   int unsigned                    scans_sent = 0;
   bit                             sender_gaps_on = 1'b1;
   bit                             squeeze_now = 1'b0;

   // timing plans for the random part, extremes included
   logic [15:0] plan_debounce [PLAN_PHASES] = '{16'd20, 16'd0, 16'd65535, 16'd1,
                                                16'd3, 16'd0, 16'd5, 16'd0};
   logic [15:0] plan_long     [PLAN_PHASES] = '{16'd600, 16'd0, 16'd65535, 16'd1,
                                                16'd10, 16'd40, 16'd2, 16'd0};
   logic [15:0] plan_repeat   [PLAN_PHASES] = '{16'd0, 16'd1, 16'd65535, 16'd0,
                                                16'd4, 16'd7, 16'd65535, 16'd0};

   key_debounce_event_fsm_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   kde_event_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .pending_count    (pending_count),
      .mismatch_count   (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("Mismatches found");
      $finish;
   end

   // offer one scan and hold it until the transfer, then maybe idle
   task automatic send_scan(input logic pressed,
                            input logic [kde_pkg::TIME_WIDTH-1:0] stamp);
      kde_pkg::req_payload_type scan;
      int unsigned              gap;
      int unsigned              r;
      scan.key_level = pressed;
      scan.time_now  = stamp;
      req_valid <= 1'b1;
      req_data  <= scan;
      do @(posedge clock); while (req_stall);
      scans_sent++;
      r = $urandom_range(0, 99);
      if (!sender_gaps_on || r < 65) gap = 0;
      else if (r < 95) gap = $urandom_range(1, 3);
      else gap = $urandom_range(10, 40);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // next timestamp: mostly forward steps near the thresholds, now and then a jump
   function automatic logic [kde_pkg::TIME_WIDTH-1:0] step_clock();
      if ($urandom_range(0, 49) == 0) now_ms = $urandom;
      else if ($urandom_range(0, 2) == 0) now_ms += $urandom_range(0, 2 * settle_ms);
      else now_ms += $urandom_range(0, span_ms);
      return now_ms;
   endfunction

   // stop offering and let every expected event come out, then a little slack
   // for a last scan that yields nothing
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (8) @(posedge clock);
   endtask

   // write all timing registers back to back while the block is idle
   task automatic load_timing(input logic [15:0] db, input logic [15:0] lp,
                              input logic [15:0] rp);
      drain();
      csr_write_enable <= 1'b1;
      csr_index        <= kde_pkg::CSR_DEBOUNCE_TIME;
      csr_write_data   <= db;
      @(posedge clock);
      csr_index        <= kde_pkg::CSR_LONG_PRESS_TIME;
      csr_write_data   <= lp;
      @(posedge clock);
      csr_index        <= kde_pkg::CSR_REPEAT_PERIOD;
      csr_write_data   <= rp;
      @(posedge clock);
      // stray write to the empty slot, must change nothing
      csr_index        <= CSR_UNUSED;
      csr_write_data   <= 16'($urandom);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      settle_ms = (db == 16'd0) ? 1 : db;
      span_ms   = (settle_ms + lp) / 5 + rp / 2 + 1;
   endtask

   // one keystroke: rest, chatter, hold, chatter, rest; some are pure noise
   task automatic key_episode();
      int unsigned n;
      if ($urandom_range(0, 6) == 0) begin
         n = $urandom_range(1, 12);
         repeat (n) send_scan(1'($urandom_range(0, 1)), step_clock());
      end else begin
         n = $urandom_range(0, 3);
         repeat (n) send_scan(1'b0, step_clock());
         n = $urandom_range(0, 2);
         repeat (n) begin
            send_scan(1'b1, step_clock());
            send_scan(1'b0, step_clock());
         end
         n = $urandom_range(1, 14);
         repeat (n) send_scan(1'b1, step_clock());
         n = $urandom_range(0, 2);
         repeat (n) begin
            send_scan(1'b0, step_clock());
            send_scan(1'b1, step_clock());
         end
         n = $urandom_range(1, 4);
         repeat (n) send_scan(1'b0, step_clock());
      end
   endtask

   // receiver: short random stalls, rare long ones, one very long hold on request
   initial begin : receiver
      int unsigned hold;
      int unsigned run;
      int unsigned r;
      rsp_stall <= 1'b0;
      repeat (6) @(posedge clock);
      forever begin
         r = $urandom_range(0, 99);
         if (squeeze_now) begin
            squeeze_now = 1'b0;
            hold = 300;
         end else if (r < 55) begin
            hold = 0;
         end else if (r < 95) begin
            hold = $urandom_range(1, 3);
         end else begin
            hold = $urandom_range(20, 60);
         end
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         // mostly short free runs, sometimes a long stretch with no stall
         run = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 100) : $urandom_range(1, 6);
         repeat (run) @(posedge clock);
      end
   end

   initial begin : stimulus
      int unsigned phase_start;
      logic [15:0] db;
      logic [15:0] lp;
      logic [15:0] rp;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_data         <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= '0;
      csr_write_data   <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset timing: 20 ms debounce, 600 ms long press, no repeat
      send_scan(1'b0, 32'h0000_0000);      // released at time zero, nothing
      send_scan(1'b1, 32'hFFFF_FFF0);      // going down
      send_scan(1'b0, 32'hFFFF_FFF5);      // bounce back to idle
      send_scan(1'b1, 32'hFFFF_FFF8);      // going down again, edge just before wrap
      send_scan(1'b1, 32'h0000_000B);      // 19 ms across the wrap, still waiting
      send_scan(1'b1, 32'h0000_000C);      // 20 ms: press, hold counts from this scan
      send_scan(1'b1, 32'h0000_0263);      // one short of long press
      send_scan(1'b1, 32'h0000_0264);      // long press
      send_scan(1'b0, 32'h0000_0300);      // going up
      send_scan(1'b1, 32'h0000_0305);      // bounce during release, back to down
      send_scan(1'b1, 32'h0000_0400);      // repeat off, nothing
      send_scan(1'b0, 32'h0000_0410);      // going up
      send_scan(1'b0, 32'h0000_0424);      // release alone, long press already fired
      send_scan(1'b1, 32'h0000_0500);      // going down
      send_scan(1'b1, 32'h0000_0514);      // press
      send_scan(1'b0, 32'h0000_0520);      // going up
      send_scan(1'b0, 32'h0000_0534);      // release then click
      send_scan(1'b0, 32'hFFFF_FFFF);      // idle at the top of the range

      // zero debounce acts as one, zero long press, short repeat
      load_timing(16'd0, 16'd0, 16'd3);
      send_scan(1'b1, 32'd1000);           // going down
      send_scan(1'b1, 32'd1000);           // no time passed, no press
      send_scan(1'b1, 32'd1001);           // press after the one ms floor
      send_scan(1'b1, 32'd1001);           // long press at once
      send_scan(1'b1, 32'd1003);           // repeat not due yet
      send_scan(1'b1, 32'd1010);           // one repeat, missed periods dropped
      send_scan(1'b1, 32'd1012);           // re-anchored, not due

      // random part, start near the wrap point
      now_ms = 32'hFFFF_F000;
      for (int p = 0; p < PLAN_PHASES; p++) begin
         db = plan_debounce[p];
         lp = plan_long[p];
         rp = plan_repeat[p];
         if (p == PLAN_PHASES - 1) begin
            db = $urandom_range(0, 30);
            lp = $urandom_range(0, 200);
            rp = $urandom_range(0, 40);
         end
         load_timing(db, lp, rp);
         sender_gaps_on = !(p == 2 || p == 6);
         // long receiver hold while the sender keeps offering, so the
         // result queue fills and req_stall has to rise
         if (p == 1 || p == 5) squeeze_now = 1'b1;
         phase_start = scans_sent;
         while (scans_sent - phase_start < PHASE_SCANS) key_episode();
      end

      drain();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
